@@ src/pspc_pkg.sv @@
// Shared types and constants for the PMT section PID collector.
package pspc_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 13;
   localparam int LEN_W    = 12;
   localparam int PID_W    = 13;
   localparam int PROG_W   = 16;
   localparam int SEEN_W   = 4;
   localparam int SLOT_W   = 3;
   localparam int PHASE_W  = 3;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_E0     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_E1     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_E2     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_E3     = 3'd5;
   localparam logic [PHASE_W-1:0] PH_E4     = 3'd6;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

   // header byte positions
   localparam logic [POS_W-1:0] POS_SLEN_HI = 13'd1;
   localparam logic [POS_W-1:0] POS_SLEN_LO = 13'd2;
   localparam logic [POS_W-1:0] POS_PROG_HI = 13'd3;
   localparam logic [POS_W-1:0] POS_PROG_LO = 13'd4;
   localparam logic [POS_W-1:0] POS_PINF_HI = 13'd10;
   localparam logic [POS_W-1:0] POS_PINF_LO = 13'd11;
   localparam logic [POS_W-1:0] POS_MAX     = 13'h1FFF;

   localparam logic [BYTE_W-1:0] TYPE_VIDEO = 8'd2;
   localparam logic [BYTE_W-1:0] TYPE_AUDIO = 8'd3;
   localparam logic [SEEN_W-1:0] SEEN_MAX   = 4'd15;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_kind;
      logic [PID_W-1:0]  stream_pid;
      logic [LEN_W-1:0]  es_info_len;
      logic [PROG_W-1:0] prog_number;
      logic              video_added;
      logic              audio_added;
      logic [SLOT_W-1:0] slot_index;
      logic              list_full;
      logic              entry_last;
   } pspc_result_type;

endpackage

@@ src/pmt_section_pid_collector_unit.sv @@
// Top level of the PMT section PID collector: input register, parser, result register.
//
// Usage:
//   req_ channel carries one PMT section byte per transaction; req_tuser marks the
//   table_id byte that opens a section. Each elementary stream entry gives one
//   result transaction on the rsp_ channel once its fifth header byte is parsed;
//   rsp_tlast flags the last entry parsed in the section.
//   Video entries (stream type 2) feed a deduplicated PID list and audio entries
//   (stream type 3) a per-program list, both LIST_DEPTH deep, kept across sections.
//   A byte and its result pass through the input register, then the result register,
//   before rsp_tvalid. Throughput: one byte per cycle unless a result stalls, set by
//   the single parser stage, whose state update and list compares are combinational.
//   Stall: while a result waits in the result register, bytes that give no result
//   still move through; a byte that gives a result waits in the input register
//   and req_tready drops only when both registers are held.
//   Reset: synchronous, clears the parser state and both list counts; parsing
//   begins as if a section started at reset. No clearing pass is needed.
module pmt_section_pid_collector_unit
   import pspc_pkg::*;
#(
   parameter int LIST_DEPTH  = 7,
   parameter int MAX_ENTRIES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] section_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [12:0] stream_pid, [24:13] es_info_len, [40:25] prog_number, [41] video_added,
   // [42] audio_added, [45:43] slot_index, [46] list_full, [47] zero
   output logic [47:0] rsp_tdata,
   output logic [7:0]  rsp_tuser,   // [7:0] stream_kind
   output logic        rsp_tlast    // entry_last
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pspc_result_type   rsp_data_ff;
   pspc_result_type   result;
   logic              has_result;
   logic              out_free;
   logic              step;
   logic              req_xact;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || step;
   assign req_xact   = req_tvalid && req_tready;

   assign in_valid_in  = req_xact ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && has_result) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   pspc_parser #(.LIST_DEPTH(LIST_DEPTH), .MAX_ENTRIES(MAX_ENTRIES)) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (in_byte_ff),
      .section_start (in_start_ff),
      .has_result    (has_result),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xact) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (step && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.stream_kind;
   assign rsp_tlast  = rsp_data_ff.entry_last;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.list_full,
                        rsp_data_ff.slot_index,
                        rsp_data_ff.audio_added,
                        rsp_data_ff.video_added,
                        rsp_data_ff.prog_number,
                        rsp_data_ff.es_info_len,
                        rsp_data_ff.stream_pid};

   // an entry is never both a video and an audio add
   a_single_add: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data_ff.video_added && rsp_data_ff.audio_added))
      else $error("video and audio add in one result");

   // a dropped add reports no slot and no add
   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.list_full) |->
         (rsp_data_ff.slot_index == '0 && !rsp_data_ff.video_added &&
          !rsp_data_ff.audio_added))
      else $error("list_full result with slot or add set");

   // an accepted byte lands in the input register
   a_input_loaded: assert property (@(posedge clock) disable iff (reset)
      req_xact |=> in_valid_ff)
      else $error("accepted byte lost from input register");

   // a held result is not overwritten by the parser
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(step && has_result))
      else $error("result register overwritten while stalled");

endmodule

@@ src/pspc_list.sv @@
// Saturating value list with parallel compare over valid slots; hit lets the caller skip duplicates.
module pspc_list
   import pspc_pkg::*;
#(
   parameter int DEPTH = 7,
   parameter int WIDTH = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [WIDTH-1:0]                 value,
   input  logic                             add_en,
   output logic                             hit,
   output logic                             full,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] list_ff [DEPTH];
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if ((count_ff > CW'(i)) && (list_ff[i] == value)) begin
            hit = 1'b1;
         end
      end
   end

   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign count_in = (add_en && !full) ? count_ff + 1'b1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (add_en && !full && (count_ff == CW'(i))) begin
            list_ff[i] <= value;
         end
      end
   end

endmodule

@@ src/pspc_parser.sv @@
// Section byte parser: header capture, descriptor skipping, entry decode, list updates.
module pspc_parser
   import pspc_pkg::*;
#(
   parameter int LIST_DEPTH  = 7,
   parameter int MAX_ENTRIES = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              section_start,
   output logic              has_result,
   output pspc_result_type   result
);

   localparam int CW = $clog2(LIST_DEPTH + 1);

   logic [POS_W-1:0]   byte_position_ff, byte_position_in;
   logic [LEN_W-1:0]   section_len_ff, section_len_in;
   logic [PROG_W-1:0]  program_ff, program_in;
   logic [LEN_W-1:0]   prog_info_len_ff, prog_info_len_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  entry_type_ff, entry_type_in;
   logic [PID_W-1:0]   entry_pid_ff, entry_pid_in;
   logic [LEN_W-1:0]   skip_left_ff, skip_left_in;
   logic [SEEN_W-1:0]  entries_seen_ff, entries_seen_in;

   // state as seen by this byte (start flag clears the section context)
   logic [POS_W-1:0]   pos;
   logic [LEN_W-1:0]   slen;
   logic [PROG_W-1:0]  prog;
   logic [LEN_W-1:0]   pinf;
   logic [PHASE_W-1:0] phase;
   logic [LEN_W-1:0]   skip;
   logic [SEEN_W-1:0]  seen;
   logic [SEEN_W-1:0]  seen_next;
   logic [LEN_W-1:0]   es_len;
   logic [LEN_W-1:0]   pinf_full;
   logic               no_room_now;
   logic               no_room_next;
   logic               is_video, is_audio;
   logic               v_hit, v_full, a_hit, a_full;
   logic               v_add, a_add;
   logic [CW-1:0]      v_count, a_count;

   assign pos   = section_start ? '0 : byte_position_ff;
   assign slen  = section_start ? '0 : section_len_ff;
   assign prog  = section_start ? '0 : program_ff;
   assign pinf  = section_start ? '0 : prog_info_len_ff;
   assign phase = section_start ? PH_HEADER : phase_ff;
   assign skip  = section_start ? '0 : skip_left_ff;
   assign seen  = section_start ? '0 : entries_seen_ff;

   assign es_len    = {skip[LEN_W-1:BYTE_W], data_byte};
   assign pinf_full = {pinf[LEN_W-1:BYTE_W], data_byte};
   assign seen_next = (seen < SEEN_MAX) ? seen + 1'b1 : seen;

   // entry header must fit before the CRC: pos + 5 > len - 1
   assign no_room_now  = ({1'b0, pos} + 14'd6) > {2'b0, slen};
   // next entry starts at pos + 1 + es_len
   assign no_room_next = ({2'b0, pos} + {3'b0, es_len} + 15'd7) > {3'b0, slen};

   assign has_result = (phase == PH_E4);
   assign is_video   = has_result && (entry_type_ff == TYPE_VIDEO);
   assign is_audio   = has_result && (entry_type_ff == TYPE_AUDIO);
   assign v_add      = step && is_video && !v_hit;
   assign a_add      = step && is_audio && !a_hit;

   pspc_list #(.DEPTH(LIST_DEPTH), .WIDTH(PID_W)) u_video_list (
      .clock  (clock),
      .reset  (reset),
      .value  (entry_pid_ff),
      .add_en (v_add),
      .hit    (v_hit),
      .full   (v_full),
      .count  (v_count)
   );

   pspc_list #(.DEPTH(LIST_DEPTH), .WIDTH(PROG_W)) u_audio_list (
      .clock  (clock),
      .reset  (reset),
      .value  (prog),
      .add_en (a_add),
      .hit    (a_hit),
      .full   (a_full),
      .count  (a_count)
   );

   always_comb begin
      byte_position_in = (pos < POS_MAX) ? pos + 1'b1 : pos;
      section_len_in   = slen;
      program_in       = prog;
      prog_info_len_in = pinf;
      phase_in         = phase;
      entry_type_in    = entry_type_ff;
      entry_pid_in     = entry_pid_ff;
      skip_left_in     = skip;
      entries_seen_in  = seen;

      result             = '0;
      result.stream_kind = entry_type_ff;
      result.stream_pid  = entry_pid_ff;
      result.es_info_len = es_len;
      result.prog_number = prog;

      case (phase)
         PH_HEADER: begin
            case (pos)
               POS_SLEN_HI: section_len_in = {data_byte[3:0], 8'h00};
               POS_SLEN_LO: section_len_in = {slen[LEN_W-1:BYTE_W], data_byte};
               POS_PROG_HI: program_in = {data_byte, 8'h00};
               POS_PROG_LO: program_in = {prog[PROG_W-1:BYTE_W], data_byte};
               POS_PINF_HI: prog_info_len_in = {data_byte[3:0], 8'h00};
               POS_PINF_LO: begin
                  prog_info_len_in = pinf_full;
                  if (pinf_full != '0) begin
                     skip_left_in = pinf_full;
                     phase_in     = PH_SKIP;
                  end else begin
                     phase_in = PH_E0;
                  end
               end
               default: ;
            endcase
         end
         PH_SKIP: begin
            if (skip != '0) begin
               skip_left_in = skip - 1'b1;
            end
            if (skip <= 12'd1) begin
               phase_in = PH_E0;
            end
         end
         PH_E0: begin
            if ((seen >= SEEN_W'(MAX_ENTRIES)) || no_room_now) begin
               phase_in = PH_DONE;
            end else begin
               entry_type_in = data_byte;
               phase_in      = PH_E1;
            end
         end
         PH_E1: begin
            entry_pid_in = {data_byte[4:0], 8'h00};
            phase_in     = PH_E2;
         end
         PH_E2: begin
            entry_pid_in = {entry_pid_ff[PID_W-1:BYTE_W], data_byte};
            phase_in     = PH_E3;
         end
         PH_E3: begin
            skip_left_in = {data_byte[3:0], 8'h00};
            phase_in     = PH_E4;
         end
         PH_E4: begin
            entries_seen_in = seen_next;
            if (is_video && !v_hit) begin
               if (!v_full) begin
                  result.video_added = 1'b1;
                  result.slot_index  = SLOT_W'(v_count);
               end else begin
                  result.list_full = 1'b1;
               end
            end
            if (is_audio && !a_hit) begin
               if (!a_full) begin
                  result.audio_added = 1'b1;
                  result.slot_index  = SLOT_W'(a_count);
               end else begin
                  result.list_full = 1'b1;
               end
            end
            result.entry_last = (seen_next >= SEEN_W'(MAX_ENTRIES)) || no_room_next;
            if (result.entry_last) begin
               phase_in     = PH_DONE;
               skip_left_in = '0;
            end else if (es_len != '0) begin
               skip_left_in = es_len;
               phase_in     = PH_SKIP;
            end else begin
               skip_left_in = '0;
               phase_in     = PH_E0;
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         section_len_ff   <= '0;
         program_ff       <= '0;
         prog_info_len_ff <= '0;
         phase_ff         <= PH_HEADER;
         entry_type_ff    <= '0;
         entry_pid_ff     <= '0;
         skip_left_ff     <= '0;
         entries_seen_ff  <= '0;
      end else if (step) begin
         byte_position_ff <= byte_position_in;
         section_len_ff   <= section_len_in;
         program_ff       <= program_in;
         prog_info_len_ff <= prog_info_len_in;
         phase_ff         <= phase_in;
         entry_type_ff    <= entry_type_in;
         entry_pid_ff     <= entry_pid_in;
         skip_left_ff     <= skip_left_in;
         entries_seen_ff  <= entries_seen_in;
      end
   end

endmodule

@@ tb/sv/pmt_section_pid_collector_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the PMT section PID collector: directed and random sections.
module pmt_section_pid_collector_unit_test;
   import pspc_pkg::*;

   localparam int LIST_DEPTH   = 7;
   localparam int MAX_ENTRIES  = 10;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RANDOM_BYTES = 160;

   typedef logic [BYTE_W-1:0] section_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [7:0]  rsp_tuser;
   logic        rsp_tlast;

   pmt_section_pid_collector_unit #(
      .LIST_DEPTH  (LIST_DEPTH),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // parser state mirror
   logic [POS_W-1:0]   sec_pos;
   logic [LEN_W-1:0]   sec_len_q;
   logic [PROG_W-1:0]  prog_q;
   logic [LEN_W-1:0]   pinfo_q;
   logic [PHASE_W-1:0] phase_q;
   logic [BYTE_W-1:0]  kind_q;
   logic [PID_W-1:0]   pid_q;
   logic [LEN_W-1:0]   skip_q;
   logic [SEEN_W-1:0]  seen_q;
   logic [PID_W-1:0]   video_pids [LIST_DEPTH];
   int                 video_used;
   logic [PROG_W-1:0]  audio_progs [LIST_DEPTH];
   int                 audio_used;

   pspc_result_type    expected_entries [$];
   section_byte_type   frame_bytes [$];

   int mismatches    = 0;
   int bytes_sent    = 0;
   bit tx_pace       = 1'b1;
   bit rx_pace       = 1'b1;
   bit long_hold_req = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic void restart_section();
      sec_pos   = '0;
      sec_len_q = '0;
      prog_q    = '0;
      pinfo_q   = '0;
      phase_q   = PH_HEADER;
      kind_q    = '0;
      pid_q     = '0;
      skip_q    = '0;
      seen_q    = '0;
   endfunction

   // Advances the parser mirror by one section byte; queues the entry it completes, if any.
   function automatic void parse_pmt_byte(input section_byte_type b, input logic start);
      logic [POS_W-1:0] at;
      logic [LEN_W-1:0] es_len;
      int               area_end;
      int               next_start;
      int               i;
      bit               known;
      pspc_result_type  r;
      if (start)
         restart_section();
      at = sec_pos;
      if (sec_pos != POS_MAX)
         sec_pos = sec_pos + 1'b1;
      // entry area ends ahead of the CRC
      area_end = int'(sec_len_q) - 1;
      case (phase_q)
         PH_HEADER: begin
            if (at == POS_SLEN_HI) sec_len_q = {b[3:0], 8'h00};
            else if (at == POS_SLEN_LO) sec_len_q = sec_len_q | {4'h0, b};
            else if (at == POS_PROG_HI) prog_q = {b, 8'h00};
            else if (at == POS_PROG_LO) prog_q = prog_q | {8'h00, b};
            else if (at == POS_PINF_HI) pinfo_q = {b[3:0], 8'h00};
            else if (at == POS_PINF_LO) begin
               pinfo_q = pinfo_q | {4'h0, b};
               if (pinfo_q != '0) begin
                  skip_q  = pinfo_q;
                  phase_q = PH_SKIP;
               end else begin
                  phase_q = PH_E0;
               end
            end
         end
         PH_SKIP: begin
            if (skip_q != '0)
               skip_q = skip_q - 1'b1;
            if (skip_q == '0)
               phase_q = PH_E0;
         end
         PH_E0: begin
            if (seen_q >= MAX_ENTRIES || int'(at) + 5 > area_end) begin
               phase_q = PH_DONE;
            end else begin
               kind_q  = b;
               phase_q = PH_E1;
            end
         end
         PH_E1: begin
            pid_q   = {b[4:0], 8'h00};
            phase_q = PH_E2;
         end
         PH_E2: begin
            pid_q   = pid_q | {5'h00, b};
            phase_q = PH_E3;
         end
         PH_E3: begin
            skip_q  = {b[3:0], 8'h00};
            phase_q = PH_E4;
         end
         PH_E4: begin
            es_len     = skip_q | {4'h0, b};
            next_start = int'(at) + 1 + int'(es_len);
            r             = '0;
            r.stream_kind = kind_q;
            r.stream_pid  = pid_q;
            r.es_info_len = es_len;
            r.prog_number = prog_q;
            if (kind_q == TYPE_VIDEO) begin
               known = 1'b0;
               for (i = 0; i < video_used; i++)
                  if (video_pids[i] == pid_q) known = 1'b1;
               if (!known) begin
                  if (video_used < LIST_DEPTH) begin
                     r.slot_index           = SLOT_W'(video_used);
                     video_pids[video_used] = pid_q;
                     video_used++;
                     r.video_added = 1'b1;
                  end else begin
                     r.list_full = 1'b1;
                  end
               end
            end
            // audio list is keyed by program number, one PID per program
            if (kind_q == TYPE_AUDIO) begin
               known = 1'b0;
               for (i = 0; i < audio_used; i++)
                  if (audio_progs[i] == prog_q) known = 1'b1;
               if (!known) begin
                  if (audio_used < LIST_DEPTH) begin
                     r.slot_index            = SLOT_W'(audio_used);
                     audio_progs[audio_used] = prog_q;
                     audio_used++;
                     r.audio_added = 1'b1;
                  end else begin
                     r.list_full = 1'b1;
                  end
               end
            end
            if (seen_q != SEEN_MAX)
               seen_q = seen_q + 1'b1;
            r.entry_last = (seen_q >= MAX_ENTRIES) || (next_start + 5 > area_end);
            if (r.entry_last) begin
               phase_q = PH_DONE;
               skip_q  = '0;
            end else if (es_len != '0) begin
               skip_q  = es_len;
               phase_q = PH_SKIP;
            end else begin
               skip_q  = '0;
               phase_q = PH_E0;
            end
            expected_entries.push_back(r);
         end
         default: phase_q = PH_DONE;
      endcase
   endfunction

   function automatic int pick_gap(input bit paced);
      int roll;
      if (!paced)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [3:0] rand_nibble();
      return 4'($urandom);
   endfunction

   // One transaction on the section byte channel; the mirror advances on acceptance.
   task automatic send_byte(input section_byte_type b, input logic start);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      parse_pmt_byte(b, start);
      bytes_sent++;
      gap = pick_gap(tx_pace);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic begin_frame(input logic [15:0] prog, input logic [11:0] pinfo);
      frame_bytes.delete();
      frame_bytes.push_back(8'h02);
      // section length bytes are patched in close_frame
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(prog[15:8]);
      frame_bytes.push_back(prog[7:0]);
      repeat (5) frame_bytes.push_back(section_byte_type'($urandom));
      frame_bytes.push_back({rand_nibble(), pinfo[11:8]});
      frame_bytes.push_back(pinfo[7:0]);
      repeat (int'(pinfo)) frame_bytes.push_back(section_byte_type'($urandom));
   endtask

   task automatic add_entry(input section_byte_type kind, input logic [12:0] pid,
                            input logic [11:0] es_len, input int desc_bytes);
      frame_bytes.push_back(kind);
      frame_bytes.push_back({3'($urandom), pid[12:8]});
      frame_bytes.push_back(pid[7:0]);
      frame_bytes.push_back({rand_nibble(), es_len[11:8]});
      frame_bytes.push_back(es_len[7:0]);
      repeat (desc_bytes) frame_bytes.push_back(section_byte_type'($urandom));
   endtask

   // adjust 0 gives a consistent length; other values move the section end
   task automatic close_frame(input int adjust);
      int          slen;
      logic [11:0] slen_v;
      slen = frame_bytes.size() + 1 + adjust;
      if (slen < 0) slen = 0;
      if (slen > 4095) slen = 4095;
      slen_v = 12'(slen);
      frame_bytes[1] = {rand_nibble(), slen_v[11:8]};
      frame_bytes[2] = slen_v[7:0];
      repeat (4) frame_bytes.push_back(section_byte_type'($urandom));
   endtask

   task automatic send_frame(input bit flagged, input int count);
      int i;
      for (i = 0; i < count && i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], flagged && i == 0);
   endtask

   task automatic test_headless_start;
      // first section after reset carries no start flag
      begin_frame(16'h0000, 12'd0);
      add_entry(TYPE_VIDEO, 13'h1FFF, 12'd0, 0);
      add_entry(TYPE_AUDIO, 13'h0000, 12'd0, 0);
      close_frame(0);
      send_frame(1'b0, frame_bytes.size());
   endtask

   task automatic test_stream_types;
      begin_frame(16'hFFFF, 12'd3);
      add_entry(8'h00, 13'h0100, 12'd2, 2);
      add_entry(8'hFF, 13'h0ABC, 12'd1, 1);
      add_entry(TYPE_VIDEO, 13'h1FFF, 12'd0, 0);
      add_entry(TYPE_AUDIO, 13'h0123, 12'd0, 0);
      // declared maximum ES info length on the last entry, few bytes follow
      add_entry(TYPE_VIDEO, 13'h0020, 12'hFFF, 3);
      close_frame(0);
      send_frame(1'b1, frame_bytes.size());
   endtask

   task automatic test_restart;
      begin_frame(16'h1234, 12'd0);
      add_entry(TYPE_VIDEO, 13'h0021, 12'd0, 0);
      add_entry(8'h06, 13'h0022, 12'd0, 0);
      add_entry(8'h06, 13'h0023, 12'd0, 0);
      close_frame(0);
      send_frame(1'b1, 20);
      send_frame(1'b1, 7);
      begin_frame(16'h1235, 12'd2);
      add_entry(8'h1B, 13'h0024, 12'd1, 1);
      add_entry(8'h0F, 13'h0025, 12'd0, 0);
      close_frame(0);
      send_frame(1'b1, frame_bytes.size());
   endtask

   task automatic test_section_end;
      begin_frame(16'h4321, 12'd0);
      add_entry(TYPE_VIDEO, 13'h0033, 12'd1, 1);
      add_entry(8'h06, 13'h0034, 12'd0, 0);
      add_entry(8'h06, 13'h0035, 12'd0, 0);
      close_frame(-6);
      send_frame(1'b1, frame_bytes.size());
      // zero section length: no entry fits
      begin_frame(16'h4322, 12'd0);
      add_entry(TYPE_AUDIO, 13'h0036, 12'd0, 0);
      close_frame(-1000);
      send_frame(1'b1, frame_bytes.size());
   endtask

   task automatic test_entry_cap;
      int i;
      tx_pace = 1'b0;
      begin_frame(16'h2000, 12'd1);
      for (i = 0; i < MAX_ENTRIES + 2; i++)
         add_entry(8'h1B, 13'($urandom), 12'd0, 0);
      close_frame(0);
      send_frame(1'b1, frame_bytes.size());
      tx_pace = 1'b1;
   endtask

   task automatic test_descriptor_overrun;
      // program descriptors run past the section end
      begin_frame(16'h0500, 12'd40);
      add_entry(TYPE_VIDEO, 13'h0050, 12'd0, 0);
      close_frame(-30);
      send_frame(1'b1, frame_bytes.size());
   endtask

   task automatic test_list_full;
      int i;
      begin_frame(16'h0600, 12'd0);
      for (i = 0; i < LIST_DEPTH + 1; i++)
         add_entry(TYPE_VIDEO, 13'h0100 + 13'(i), 12'd0, 0);
      add_entry(TYPE_VIDEO, 13'h0100, 12'd0, 0);
      close_frame(0);
      send_frame(1'b1, frame_bytes.size());
      for (i = 0; i < LIST_DEPTH + 1; i++) begin
         begin_frame(16'h0700 + 16'(i), 12'd0);
         add_entry(TYPE_AUDIO, 13'(i), 12'd0, 0);
         add_entry(TYPE_AUDIO, 13'(i + 1), 12'd0, 0);
         close_frame(0);
         send_frame(1'b1, frame_bytes.size());
      end
   endtask

   task automatic test_result_backpressure;
      int i;
      req_tvalid <= 1'b0;
      @(posedge clock);
      long_hold_req = 1'b1;
      wait (!long_hold_req);
      // back-to-back entries while the result side is held off
      tx_pace = 1'b0;
      begin_frame(16'h0300, 12'd0);
      for (i = 0; i < MAX_ENTRIES; i++)
         add_entry(i[0] ? TYPE_AUDIO : 8'h06, 13'($urandom), 12'd0, 0);
      close_frame(0);
      send_frame(1'b1, frame_bytes.size());
      tx_pace = 1'b1;
   endtask

   task automatic test_long_input;
      int i;
      // a start byte followed by unflagged filler at full rate
      tx_pace = 1'b0;
      rx_pace = 1'b0;
      send_byte(8'h02, 1'b1);
      for (i = 0; i < 30; i++)
         send_byte(section_byte_type'($urandom), 1'b0);
      tx_pace = 1'b1;
      rx_pace = 1'b1;
   endtask

   task automatic test_random_sections;
      int               first;
      int               roll;
      int               n;
      int               i;
      int               cut;
      int               pick;
      section_byte_type kind;
      logic [12:0]      pid;
      logic [11:0]      es_len;
      first = bytes_sent;
      while (bytes_sent - first < RANDOM_BYTES) begin
         tx_pace = ($urandom_range(0, 3) != 0);
         rx_pace = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 88) begin
            begin_frame(($urandom_range(0, 9) < 7) ? 16'h0200 + 16'($urandom_range(0, 9))
                                                   : 16'($urandom),
                        ($urandom_range(0, 9) == 0) ? 12'($urandom_range(5, 24))
                                                    : 12'($urandom_range(0, 3)));
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
               n = $urandom_range(7, 12);
            for (i = 0; i < n; i++) begin
               pick = $urandom_range(0, 9);
               kind = (pick < 4) ? TYPE_VIDEO : (pick < 7) ? TYPE_AUDIO
                                                           : section_byte_type'($urandom);
               pid  = ($urandom_range(0, 9) < 6) ? 13'h0040 + 13'($urandom_range(0, 9))
                                                 : 13'($urandom);
               if (roll < 75) begin
                  es_len = 12'($urandom_range(0, 3));
                  add_entry(kind, pid, es_len, int'(es_len));
               end else begin
                  add_entry(kind, pid, 12'($urandom), $urandom_range(0, 3));
               end
            end
            // malformed sections get a randomly adjusted length and may be cut short
            close_frame(roll < 75 ? 0 : int'($urandom_range(0, 40)) - 20);
            cut = frame_bytes.size();
            if (roll >= 75 && $urandom_range(0, 1) == 1)
               cut = $urandom_range(1, cut);
            send_frame($urandom_range(0, 19) != 0, cut);
         end else begin
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
               send_byte(section_byte_type'($urandom), $urandom_range(0, 9) == 0);
         end
      end
   endtask

   task automatic finish_traffic;
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_entries.size() != 0)
         report_mismatch($sformatf("%0d entries never returned", expected_entries.size()));
      repeat (10) @(posedge clock);
   endtask

   // result side: random ready pattern, plus one long hold-off on request
   initial begin : rsp_pacing
      int span;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!rx_pace) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            span = pick_gap(1'b1);
            if (span > 0) begin
               rsp_tready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      pspc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_entries.size() == 0) begin
            report_mismatch("result transaction with no entry pending");
         end else begin
            want = expected_entries.pop_front();
            check_field("stream_kind", 16'(rsp_tuser), 16'(want.stream_kind));
            check_field("stream_pid", 16'(rsp_tdata[12:0]), 16'(want.stream_pid));
            check_field("es_info_len", 16'(rsp_tdata[24:13]), 16'(want.es_info_len));
            check_field("prog_number", rsp_tdata[40:25], want.prog_number);
            check_field("video_added", 16'(rsp_tdata[41]), 16'(want.video_added));
            check_field("audio_added", 16'(rsp_tdata[42]), 16'(want.audio_added));
            check_field("slot_index", 16'(rsp_tdata[45:43]), 16'(want.slot_index));
            check_field("list_full", 16'(rsp_tdata[46]), 16'(want.list_full));
            check_field("entry_last", 16'(rsp_tlast), 16'(want.entry_last));
            check_field("tdata pad", 16'(rsp_tdata[47]), 16'h0000);
         end
      end
   end

   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      restart_section();
      video_used = 0;
      audio_used = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_headless_start();
      test_stream_types();
      test_restart();
      test_section_end();
      test_entry_cap();
      test_descriptor_overrun();
      test_list_full();
      test_result_backpressure();
      test_long_input();
      test_random_sections();
      finish_traffic();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ pmt_section_pid_collector_unit.f @@
src/pspc_pkg.sv
src/pspc_list.sv
src/pspc_parser.sv
src/pmt_section_pid_collector_unit.sv
tb/sv/pmt_section_pid_collector_unit_test.sv
